[hw/rtl/scog_pkg.sv]
// Package for the spiral chunk order generator.
// Holds field widths, register codes, the walk direction type and the structs
// passed between the top level and the walker. Depends on nothing.
package scog_pkg;

  localparam int CAM_W     = 32;
  localparam int COORD_W   = 24;
  localparam int Z_W       = 4;
  localparam int FRAC_BITS = 8;
  localparam int SHIFT_W   = 5;

  localparam int DIST_W    = 6;
  localparam int HEIGHT_W  = 4;
  localparam int CSL_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 6;

  // Wide enough for (2D+1)^2 at the largest distance the register can hold.
  localparam int TOT_W     = 2 * (DIST_W + 1);

  localparam int MAX_DISTANCE_DEF = 32;
  localparam int MAX_HEIGHT_DEF   = 15;

  localparam logic [DIST_W-1:0]   DIST_RST   = 6'd8;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 4'd3;
  localparam logic [CSL_W-1:0]    CSL_RST    = 4'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK    = 2'd2;

  localparam logic KIND_CAMERA = 1'b0;
  localparam logic KIND_PULL   = 1'b1;

  localparam int TDATA_OUT_W = 56;
  localparam int TUSER_OUT_W = 2;
  localparam int TU_VALID    = 0;
  localparam int TU_RESTART  = 1;

  typedef enum logic [1:0] {
    DIR_DOWN  = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_UP    = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  typedef struct packed {
    logic [DIST_W-1:0]   radius;
    logic [HEIGHT_W-1:0] height;
    logic [CSL_W-1:0]    csl;
  } cfg_t;

  typedef struct packed {
    logic                    kind;
    logic signed [CAM_W-1:0] cam_x;
    logic signed [CAM_W-1:0] cam_y;
  } item_t;

  typedef struct packed {
    logic               valid_res;
    logic [COORD_W-1:0] chunk_x;
    logic [COORD_W-1:0] chunk_y;
    logic [Z_W-1:0]     chunk_z;
    logic               final_item;
    logic               restarted;
  } res_t;

endpackage

[hw/rtl/scog_walker.sv]
// Spiral walker: chunk tracking and the square spiral walk state.
// Produces the result word for the item presented and updates state on step_en.
// Depends on scog_pkg.
module scog_walker #(
  parameter int MAX_DISTANCE = scog_pkg::MAX_DISTANCE_DEF,
  parameter int MAX_HEIGHT   = scog_pkg::MAX_HEIGHT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  scog_pkg::item_t item,
  input  scog_pkg::cfg_t  cfg,
  output scog_pkg::res_t  res
);

  localparam int TOTAL_MAX = (2 * MAX_DISTANCE + 1) * (2 * MAX_DISTANCE + 1);
  localparam int PD_W      = $clog2(TOTAL_MAX + 1);
  localparam int LEG_W     = $clog2(2 * MAX_DISTANCE + 2);

  localparam int CW = scog_pkg::COORD_W;
  localparam int TW = scog_pkg::TOT_W;

  logic                         have_pos_r, have_pos_nxt;
  logic [CW-1:0]                last_x_r, last_x_nxt;
  logic [CW-1:0]                last_y_r, last_y_nxt;
  logic                         active_r, active_nxt;
  logic [CW-1:0]                pt_x_r, pt_x_nxt;
  logic [CW-1:0]                pt_y_r, pt_y_nxt;
  logic [scog_pkg::Z_W-1:0]     h_r, h_nxt;
  scog_pkg::dir_t               dir_r, dir_nxt;
  logic [LEG_W-1:0]             leg_len_r, leg_len_nxt;
  logic [LEG_W-1:0]             leg_step_r, leg_step_nxt;
  logic                         phase_r, phase_nxt;
  logic [PD_W-1:0]              pd_r, pd_nxt;

  logic [scog_pkg::SHIFT_W-1:0]      shamt;
  logic signed [scog_pkg::CAM_W-1:0] sh_x, sh_y;
  logic [CW-1:0]                     cx, cy;
  logic                              restart;
  logic [scog_pkg::DIST_W-1:0]       d_lim;
  logic [scog_pkg::DIST_W:0]         side;
  logic [TW-1:0]                     total;
  logic [TW-1:0]                     pd_inc;
  logic [scog_pkg::HEIGHT_W-1:0]     h_lim;
  logic                              last_col, top;
  logic [LEG_W-1:0]                  leg_step_inc;

  // The arithmetic shift floors toward minus infinity for negative positions.
  assign shamt = scog_pkg::SHIFT_W'(scog_pkg::FRAC_BITS) + {1'b0, cfg.csl};
  assign sh_x  = item.cam_x >>> shamt;
  assign sh_y  = item.cam_y >>> shamt;
  assign cx    = sh_x[CW-1:0];
  assign cy    = sh_y[CW-1:0];
  assign restart = !have_pos_r || (cx != last_x_r) || (cy != last_y_r);

  assign d_lim = (int'(cfg.radius) > MAX_DISTANCE) ?
                 scog_pkg::DIST_W'(MAX_DISTANCE) : cfg.radius;
  assign h_lim = (int'(cfg.height) > MAX_HEIGHT) ?
                 scog_pkg::HEIGHT_W'(MAX_HEIGHT) : cfg.height;
  assign side  = {d_lim, 1'b1};
  assign total = TW'(side) * TW'(side);
  assign pd_inc = TW'(pd_r) + TW'(1);
  assign last_col = pd_inc >= total;
  assign top      = h_r >= h_lim;
  assign leg_step_inc = leg_step_r + LEG_W'(1);

  always_comb begin
    res          = '0;
    have_pos_nxt = have_pos_r;
    last_x_nxt   = last_x_r;
    last_y_nxt   = last_y_r;
    active_nxt   = active_r;
    pt_x_nxt     = pt_x_r;
    pt_y_nxt     = pt_y_r;
    h_nxt        = h_r;
    dir_nxt      = dir_r;
    leg_len_nxt  = leg_len_r;
    leg_step_nxt = leg_step_r;
    phase_nxt    = phase_r;
    pd_nxt       = pd_r;

    if (item.kind == scog_pkg::KIND_CAMERA) begin
      if (restart) begin
        have_pos_nxt  = 1'b1;
        last_x_nxt    = cx;
        last_y_nxt    = cy;
        active_nxt    = 1'b1;
        pt_x_nxt      = cx;
        pt_y_nxt      = cy;
        h_nxt         = '0;
        dir_nxt       = scog_pkg::DIR_DOWN;
        leg_len_nxt   = LEG_W'(1);
        leg_step_nxt  = '0;
        phase_nxt     = 1'b0;
        pd_nxt        = '0;
        res.restarted = 1'b1;
      end
    end else if (active_r) begin
      res.valid_res  = 1'b1;
      res.chunk_x    = pt_x_r;
      res.chunk_y    = pt_y_r;
      res.chunk_z    = h_r;
      res.final_item = last_col && top;
      if (!top) begin
        h_nxt = h_r + scog_pkg::Z_W'(1);
      end else begin
        h_nxt  = '0;
        pd_nxt = pd_r + PD_W'(1);
        if (last_col) begin
          active_nxt = 1'b0;
        end else begin
          unique case (dir_r)
            scog_pkg::DIR_DOWN:  pt_y_nxt = pt_y_r - CW'(1);
            scog_pkg::DIR_LEFT:  pt_x_nxt = pt_x_r - CW'(1);
            scog_pkg::DIR_UP:    pt_y_nxt = pt_y_r + CW'(1);
            scog_pkg::DIR_RIGHT: pt_x_nxt = pt_x_r + CW'(1);
            default:             pt_x_nxt = pt_x_r;
          endcase
          if (leg_step_inc >= leg_len_r) begin
            leg_step_nxt = '0;
            dir_nxt      = scog_pkg::dir_t'(dir_r + 2'd1);
            if (phase_r) begin
              leg_len_nxt = leg_len_r + LEG_W'(1);
            end
            phase_nxt = !phase_r;
          end else begin
            leg_step_nxt = leg_step_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_pos_r <= 1'b0;
      last_x_r   <= '0;
      last_y_r   <= '0;
      active_r   <= 1'b0;
      pt_x_r     <= '0;
      pt_y_r     <= '0;
      h_r        <= '0;
      dir_r      <= scog_pkg::DIR_DOWN;
      leg_len_r  <= LEG_W'(1);
      leg_step_r <= '0;
      phase_r    <= 1'b0;
      pd_r       <= '0;
    end else if (step_en) begin
      have_pos_r <= have_pos_nxt;
      last_x_r   <= last_x_nxt;
      last_y_r   <= last_y_nxt;
      active_r   <= active_nxt;
      pt_x_r     <= pt_x_nxt;
      pt_y_r     <= pt_y_nxt;
      h_r        <= h_nxt;
      dir_r      <= dir_nxt;
      leg_len_r  <= leg_len_nxt;
      leg_step_r <= leg_step_nxt;
      phase_r    <= phase_nxt;
      pd_r       <= pd_nxt;
    end
  end

endmodule

[hw/rtl/spiral_chunk_order_generator.sv]
// Top level of the spiral chunk order generator.
// Stream ports, configuration registers, input and result registers.
// Depends on scog_pkg and scog_walker.
//
// Usage:
//   The input stream carries camera samples and pull requests, told apart by
//   in_tuser. Every accepted word yields exactly one result word on the output
//   stream. A camera sample in a new chunk restarts the square spiral walk and
//   reports restarted; each pull during a walk returns the next column coordinate
//   and height, with out_tlast on the final coordinate of the walk.
//   Path: an accepted word is registered in the input register; when it
//   advances, the walker steps on it and the result register takes its result,
//   which is offered on out_tvalid until out_tready takes it.
//   Throughput: one word per cycle while out_tready is high; the walker makes one
//   constant-time step per word, between the input register and the result register.
//   Stalls: when out_tready is low the result register holds its word and the
//   input register still takes one more word; after that in_tready goes low.
//   Configuration writes are always ready and are meant for idle periods.
//   Reset: the walk and the held position are cleared, the registers return
//   to distance 8, height 3 and chunk size log2 5.
module spiral_chunk_order_generator #(
  parameter int MAX_DISTANCE = scog_pkg::MAX_DISTANCE_DEF,
  parameter int MAX_HEIGHT   = scog_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [2*scog_pkg::CAM_W-1:0]        in_tdata,   // cam_x, cam_y
  input  logic                                in_tuser,   // kind
  // Result stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [scog_pkg::TDATA_OUT_W-1:0]    out_tdata,  // chunk_x, chunk_y, chunk_z, pad
  output logic [scog_pkg::TUSER_OUT_W-1:0]    out_tuser,  // valid_res, restarted
  output logic                                out_tlast,  // final_item
  // Configuration writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [scog_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scog_pkg::CFG_DAT_W-1:0]      cfg_data
);

  localparam int CAM_W = scog_pkg::CAM_W;

  scog_pkg::cfg_t  cfg_r;
  scog_pkg::item_t item_r;
  logic            in_v_r;
  scog_pkg::res_t  res_r;
  scog_pkg::res_t  res;
  logic            out_v_r;
  logic            advance;
  logic            in_acc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radius <= scog_pkg::DIST_RST;
      cfg_r.height <= scog_pkg::HEIGHT_RST;
      cfg_r.csl    <= scog_pkg::CSL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        scog_pkg::CFG_DISTANCE: cfg_r.radius <= cfg_data[scog_pkg::DIST_W-1:0];
        scog_pkg::CFG_HEIGHT:   cfg_r.height <= cfg_data[scog_pkg::HEIGHT_W-1:0];
        scog_pkg::CFG_CHUNK:    cfg_r.csl    <= cfg_data[scog_pkg::CSL_W-1:0];
        default:                cfg_r        <= cfg_r;
      endcase
    end
  end

  // The held word moves on whenever the result register is free or drains.
  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_acc) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.kind  <= in_tuser;
      item_r.cam_x <= $signed(in_tdata[CAM_W-1:0]);
      item_r.cam_y <= $signed(in_tdata[2*CAM_W-1:CAM_W]);
    end
  end

  scog_walker #(
    .MAX_DISTANCE(MAX_DISTANCE),
    .MAX_HEIGHT  (MAX_HEIGHT)
  ) u_walker (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(advance),
    .item   (item_r),
    .cfg    (cfg_r),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(scog_pkg::TDATA_OUT_W - 2*scog_pkg::COORD_W - scog_pkg::Z_W){1'b0}},
                       res_r.chunk_z, res_r.chunk_y, res_r.chunk_x};
  assign out_tuser  = {res_r.restarted, res_r.valid_res};
  assign out_tlast  = res_r.final_item;

  // A result with no coordinate (a camera result or a pull outside a walk) carries zero data and never ends a walk.
  a_camera_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[scog_pkg::TU_VALID] |-> out_tdata == '0 && !out_tlast)
    else $error("camera result carries coordinate data");

  // A result is either a coordinate or a restart report, never both.
  a_excl_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[scog_pkg::TU_VALID] && out_tuser[scog_pkg::TU_RESTART]))
    else $error("result flagged as both coordinate and restart");

  // A held input word that cannot move on stays held.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !advance |=> in_v_r)
    else $error("input word dropped while stalled");

  // A stalled result is not overwritten.
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready |=> out_v_r && $stable(res_r))
    else $error("stalled result changed");

endmodule

[tb/tb_spiral_chunk_order_generator.sv]
// Self-checking testbench for spiral_chunk_order_generator.
// Runs a directed table and then random phases, and checks every result word against a predictor or a typed-in result.
// Depends on scog_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_spiral_chunk_order_generator;

  localparam int ITEM_TARGET   = 1600;
  localparam int CALM_ITEMS    = 200;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_CYCLES   = 64;
  localparam int MAX_DIST      = scog_pkg::MAX_DISTANCE_DEF;
  localparam int MAX_H         = scog_pkg::MAX_HEIGHT_DEF;

  typedef enum {ROW_CAMERA, ROW_PULL, ROW_WRITE} row_op_t;

  typedef struct {
    row_op_t        op;
    logic [31:0]    a;      // cam_x, or register index for a write
    logic [31:0]    b;      // cam_y, or register value for a write
    bit             known;  // use the typed-in result instead of the predictor
    scog_pkg::res_t want;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [2*scog_pkg::CAM_W-1:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [scog_pkg::TDATA_OUT_W-1:0] out_tdata;
  logic [scog_pkg::TUSER_OUT_W-1:0] out_tuser;
  logic out_tlast;
  logic cfg_valid;
  logic cfg_ready;
  logic [scog_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [scog_pkg::CFG_DAT_W-1:0] cfg_data;

  spiral_chunk_order_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Predictor copy of the registers and the walker.
  logic [scog_pkg::DIST_W-1:0]   dist_q;
  logic [scog_pkg::HEIGHT_W-1:0] height_q;
  logic [scog_pkg::CSL_W-1:0]    csl_q;
  bit                            have_pos;
  logic [scog_pkg::COORD_W-1:0]  held_x, held_y;
  bit                            walking;
  logic [scog_pkg::COORD_W-1:0]  px, py;
  logic [scog_pkg::Z_W-1:0]      hidx;
  scog_pkg::dir_t                dir;
  logic [6:0]                    leg_len, leg_pos;
  bit                            pair_odd;
  logic [12:0]                   cols_done;

  scog_pkg::res_t pending_words[$];
  row_t plan[$];

  int  n_items, n_checked, n_restarts, n_finals, n_writes, n_errors;
  int  idle_cycles;
  int  gap_pct;
  bit  calm;
  bit  hold_req;
  logic [31:0] last_cam_x, last_cam_y;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [scog_pkg::COORD_W-1:0] to_chunk(input logic [31:0] raw);
    logic signed [31:0] v;
    v = raw;
    return scog_pkg::COORD_W'(v >>> (scog_pkg::FRAC_BITS + csl_q));
  endfunction

  function automatic scog_pkg::res_t mk_res(input bit v, input logic [23:0] x,
                                            input logic [23:0] y, input logic [3:0] z,
                                            input bit fin, input bit rs);
    scog_pkg::res_t r;
    r.valid_res  = v;
    r.chunk_x    = x;
    r.chunk_y    = y;
    r.chunk_z    = z;
    r.final_item = fin;
    r.restarted  = rs;
    return r;
  endfunction

  // Advances the predicted walker by one word and returns the result it causes.
  function automatic scog_pkg::res_t spiral_step(input logic kind, input logic [31:0] cam_x,
                                                 input logic [31:0] cam_y);
    scog_pkg::res_t r;
    logic [scog_pkg::COORD_W-1:0] cx, cy;
    int d, total, hmax;
    bit last_col, top;
    r = '0;
    if (kind == scog_pkg::KIND_CAMERA) begin
      cx = to_chunk(cam_x);
      cy = to_chunk(cam_y);
      if (!have_pos || cx != held_x || cy != held_y) begin
        have_pos  = 1;
        held_x    = cx;
        held_y    = cy;
        walking   = 1;
        px        = cx;
        py        = cy;
        hidx      = '0;
        dir       = scog_pkg::DIR_DOWN;
        leg_len   = 7'd1;
        leg_pos   = '0;
        pair_odd  = 0;
        cols_done = '0;
        r.restarted = 1'b1;
      end
      return r;
    end
    if (!walking) return r;
    d = (int'(dist_q) > MAX_DIST) ? MAX_DIST : int'(dist_q);
    total = (2 * d + 1) * (2 * d + 1);
    hmax = (int'(height_q) > MAX_H) ? MAX_H : int'(height_q);
    last_col = int'(cols_done) + 1 >= total;
    top = int'(hidx) >= hmax;
    r = mk_res(1'b1, px, py, hidx, last_col && top, 1'b0);
    if (!top) begin
      hidx = hidx + 1'b1;
    end else begin
      hidx = '0;
      cols_done = cols_done + 1'b1;
      if (last_col) begin
        walking = 0;
      end else begin
        case (dir)
          scog_pkg::DIR_DOWN:  py = py - 1'b1;
          scog_pkg::DIR_LEFT:  px = px - 1'b1;
          scog_pkg::DIR_UP:    py = py + 1'b1;
          default:             px = px + 1'b1;
        endcase
        leg_pos = leg_pos + 1'b1;
        if (leg_pos >= leg_len) begin
          leg_pos = '0;
          dir = scog_pkg::dir_t'(dir + 2'd1);
          if (pair_odd) leg_len = leg_len + 1'b1;
          pair_odd = !pair_odd;
        end
      end
    end
    return r;
  endfunction

  function automatic void add_row(input row_op_t op, input logic [31:0] a, input logic [31:0] b,
                                  input bit known, input scog_pkg::res_t want);
    row_t row;
    row.op    = op;
    row.a     = a;
    row.b     = b;
    row.known = known;
    row.want  = want;
    plan.push_back(row);
  endfunction

  task automatic send_word(input logic kind, input logic [31:0] cam_x, input logic [31:0] cam_y,
                           input bit known, input scog_pkg::res_t want);
    scog_pkg::res_t predicted;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {cam_y, cam_x};
    do @(posedge clk); while (!in_tready);
    predicted = spiral_step(kind, cam_x, cam_y);
    pending_words.push_back(known ? want : predicted);
    n_items++;
    if (kind == scog_pkg::KIND_CAMERA) begin
      last_cam_x = cam_x;
      last_cam_y = cam_y;
    end
  endtask

  // Waits until the block has delivered every expected word and gone quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [scog_pkg::CFG_IDX_W-1:0] idx,
                           input logic [scog_pkg::CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      scog_pkg::CFG_DISTANCE: dist_q = val;
      scog_pkg::CFG_HEIGHT:   height_q = val[scog_pkg::HEIGHT_W-1:0];
      scog_pkg::CFG_CHUNK:    csl_q = val[scog_pkg::CSL_W-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  function automatic logic [31:0] rand_cam();
    if ($urandom_range(0, 1) == 0) return $urandom;
    return 32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
  endfunction

  function automatic void check_field(input string name, input logic [23:0] want,
                                      input logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  // Result checker.
  always @(posedge clk) begin
    scog_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: result word with no expectation, got tdata %0h tuser %0b last %0b",
                 $time, out_tdata, out_tuser, out_tlast);
        n_errors++;
      end else begin
        want = pending_words.pop_front();
        check_field("valid_res", want.valid_res, out_tuser[scog_pkg::TU_VALID]);
        check_field("chunk_x", want.chunk_x, out_tdata[23:0]);
        check_field("chunk_y", want.chunk_y, out_tdata[47:24]);
        check_field("chunk_z", want.chunk_z, out_tdata[51:48]);
        check_field("final_item", want.final_item, out_tlast);
        check_field("restarted", want.restarted, out_tuser[scog_pkg::TU_RESTART]);
        n_checked++;
        if (want.restarted) n_restarts++;
        if (want.final_item) n_finals++;
      end
    end
  end

  // Watchdog: counts cycles in which no handshake completes.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d words still expected",
               idle_cycles, pending_words.size());
      $display("tb_spiral_chunk_order_generator failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls, one long hold-off on request, none at the end.
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    int d, h, walk_len, run, mask, phase_end;
    logic [31:0] cx, cy;
    bit first_phase;

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tuser    <= scog_pkg::KIND_CAMERA;
    in_tdata    <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= scog_pkg::CFG_DISTANCE;
    cfg_data    <= '0;
    idle_cycles = 0;
    calm        = 0;
    hold_req    = 0;
    gap_pct     = 20;
    last_cam_x  = '0;
    last_cam_y  = '0;
    first_phase = 1;

    // State after reset.
    dist_q    = scog_pkg::DIST_RST;
    height_q  = scog_pkg::HEIGHT_RST;
    csl_q     = scog_pkg::CSL_RST;
    have_pos  = 0;
    held_x    = '0;
    held_y    = '0;
    walking   = 0;
    px        = '0;
    py        = '0;
    hidx      = '0;
    dir       = scog_pkg::DIR_DOWN;
    leg_len   = 7'd1;
    leg_pos   = '0;
    pair_odd  = 0;
    cols_done = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. At reset the shift is 13 bits, distance 8, height 3.
    add_row(ROW_PULL, 32'h0, 32'h0, 1, mk_res(0, 0, 0, 0, 0, 0));
    add_row(ROW_CAMERA, 32'h0, 32'h0, 1, mk_res(0, 0, 0, 0, 0, 1));
    add_row(ROW_CAMERA, 32'h1FFF, 32'h1FFF, 1, mk_res(0, 0, 0, 0, 0, 0));
    add_row(ROW_PULL, 32'h0, 32'h0, 1, mk_res(1, 0, 0, 0, 0, 0));
    add_row(ROW_CAMERA, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, mk_res(0, 0, 0, 0, 0, 1));
    add_row(ROW_PULL, 32'h0, 32'h0, 1, mk_res(1, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 0));
    add_row(ROW_CAMERA, 32'h7FFF_FFFF, 32'h8000_0000, 1, mk_res(0, 0, 0, 0, 0, 1));
    add_row(ROW_PULL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
            mk_res(1, 24'h03FFFF, 24'hFC0000, 0, 0, 0));
    // A walk of one column with one height ends at once.
    add_row(ROW_WRITE, 32'(scog_pkg::CFG_DISTANCE), 32'd0, 0, '0);
    add_row(ROW_WRITE, 32'(scog_pkg::CFG_HEIGHT), 32'd0, 0, '0);
    add_row(ROW_CAMERA, 32'h0, 32'h0, 1, mk_res(0, 0, 0, 0, 0, 1));
    add_row(ROW_PULL, 32'h0, 32'h0, 1, mk_res(1, 0, 0, 0, 1, 0));
    add_row(ROW_PULL, 32'h0, 32'h0, 1, mk_res(0, 0, 0, 0, 0, 0));
    // Radius one: nine columns, then a pull past the end.
    add_row(ROW_WRITE, 32'(scog_pkg::CFG_DISTANCE), 32'd1, 0, '0);
    add_row(ROW_CAMERA, 32'h2000, 32'h0, 1, mk_res(0, 0, 0, 0, 0, 1));
    repeat (10) add_row(ROW_PULL, 32'h0, 32'h0, 0, '0);
    // Largest shift, then the smallest, then a saturated distance and full height.
    add_row(ROW_WRITE, 32'(scog_pkg::CFG_CHUNK), 32'd15, 0, '0);
    add_row(ROW_CAMERA, 32'h7FFF_FFFF, 32'h8000_0000, 1, mk_res(0, 0, 0, 0, 0, 1));
    add_row(ROW_PULL, 32'h0, 32'h0, 1, mk_res(1, 24'h0000FF, 24'hFFFF00, 0, 0, 0));
    add_row(ROW_WRITE, 32'(scog_pkg::CFG_CHUNK), 32'd0, 0, '0);
    add_row(ROW_WRITE, 32'(scog_pkg::CFG_DISTANCE), 32'd63, 0, '0);
    add_row(ROW_WRITE, 32'(scog_pkg::CFG_HEIGHT), 32'd15, 0, '0);
    add_row(ROW_CAMERA, 32'h100, 32'hFFFF_FF00, 1, mk_res(0, 0, 0, 0, 0, 1));
    repeat (2) add_row(ROW_PULL, 32'h0, 32'h0, 0, '0);

    foreach (plan[i]) begin
      if (plan[i].op == ROW_WRITE) begin
        settle();
        write_reg(scog_pkg::CFG_IDX_W'(plan[i].a), scog_pkg::CFG_DAT_W'(plan[i].b));
      end else begin
        send_word(plan[i].op == ROW_PULL ? scog_pkg::KIND_PULL : scog_pkg::KIND_CAMERA,
                  plan[i].a, plan[i].b, plan[i].known, plan[i].want);
      end
    end

    // Random phases. The receiver holds off once early while words keep coming.
    while (n_items < ITEM_TARGET) begin
      settle();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: d = $urandom_range(0, 2);
        6, 7:             d = $urandom_range(3, 5);
        8:                d = ($urandom_range(0, 1) == 0) ? 32 : 63;
        default:          d = $urandom_range(6, 63);
      endcase
      h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
      // Each register is written or left untouched at random; a walk still running sees a write mid-way.
      if ($urandom_range(0, 2) != 0) write_reg(scog_pkg::CFG_DISTANCE, scog_pkg::CFG_DAT_W'(d));
      if ($urandom_range(0, 2) != 0) write_reg(scog_pkg::CFG_HEIGHT, scog_pkg::CFG_DAT_W'(h));
      if ($urandom_range(0, 2) != 0)
        write_reg(scog_pkg::CFG_CHUNK, scog_pkg::CFG_DAT_W'($urandom_range(0, 15)));
      if (first_phase) hold_req = 1;
      first_phase = 0;
      gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
      phase_end = n_items + $urandom_range(60, 120);
      while (n_items < phase_end && n_items < ITEM_TARGET) begin
        calm = (n_items >= ITEM_TARGET - CALM_ITEMS);
        d = (int'(dist_q) > MAX_DIST) ? MAX_DIST : int'(dist_q);
        walk_len = (2 * d + 1) * (2 * d + 1) * (int'(height_q) + 1);
        mask = (1 << (scog_pkg::FRAC_BITS + csl_q)) - 1;
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: begin
            // New camera chunk followed by a walk, usually run to its end.
            cx = rand_cam();
            cy = rand_cam();
            send_word(scog_pkg::KIND_CAMERA, cx, cy, 0, '0);
            run = (walk_len <= 48) ? walk_len + $urandom_range(0, 2) : $urandom_range(1, 48);
            repeat (run) send_word(scog_pkg::KIND_PULL, $urandom, $urandom, 0, '0);
          end
          14, 15, 16: begin
            // Another sample inside the held chunk, then the walk goes on.
            cx = (last_cam_x & ~mask) | ($urandom & mask);
            cy = (last_cam_y & ~mask) | ($urandom & mask);
            send_word(scog_pkg::KIND_CAMERA, cx, cy, 0, '0);
            repeat ($urandom_range(1, 8))
              send_word(scog_pkg::KIND_PULL, $urandom, $urandom, 0, '0);
          end
          default: begin
            send_word($urandom_range(0, 1) ? scog_pkg::KIND_PULL : scog_pkg::KIND_CAMERA,
                      $urandom, $urandom, 0, '0);
          end
        endcase
      end
    end

    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input words and %0d register writes; %0d result words checked,",
             n_items, n_writes, n_checked);
    $display("with %0d walk restarts and %0d completed walks, %0d mismatches",
             n_restarts, n_finals, n_errors);
    if (n_errors == 0 && pending_words.size() == 0) begin
      $display("tb_spiral_chunk_order_generator passed");
    end else begin
      $display("tb_spiral_chunk_order_generator failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/scog_pkg.sv
hw/rtl/scog_walker.sv
hw/rtl/spiral_chunk_order_generator.sv
tb/tb_spiral_chunk_order_generator.sv
